/* sv/staq_pkg.sv */
package staq_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int AW          = $clog2(DEPTH);
	localparam int CW          = $clog2(DEPTH + 1);

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_KILL = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] KIND_ADDED    = 3'd0;
	localparam logic [2:0] KIND_EXPIRED  = 3'd1;
	localparam logic [2:0] KIND_FULL     = 3'd2;
	localparam logic [2:0] KIND_KILLED   = 3'd3;
	localparam logic [2:0] KIND_NOTFOUND = 3'd4;
	localparam logic [2:0] KIND_FIRED    = 3'd5;

	typedef struct packed {
		logic [31:0] atime;
		logic [15:0] aref;
		logic [15:0] akey;
	} entry_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		entry_t        wdata;
		logic [AW-1:0] raddr;
	} store_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CHK,
		ST_ADD_INS,
		ST_MV_RD,
		ST_MV_WR,
		ST_KILL_RD,
		ST_KILL_CHK,
		ST_TICK_RD,
		ST_TICK_CHK,
		ST_FIRE_RD,
		ST_FIRE_WAIT,
		ST_EMIT
	} state_t;

endpackage

/* sv/staq_store.sv */
module staq_store (
	input  logic                  clk,
	input  staq_pkg::store_req_t  req,
	output staq_pkg::entry_t      rdata
);

	staq_pkg::entry_t mem [staq_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

/* sv/sorted_alarm_timer_queue.sv */
// sorted alarm timer queue
// one request channel (in_valid/in_ready) carries op, now_time, trigger_time,
// alarm_ref and owner_key; one result channel (out_valid/out_ready) carries
// kind, fired_time, fired_ref, fired_key and last.
// the queue holds up to 16 alarms in a single-port-write, registered-read
// store, kept sorted by time. a small sequencer walks the store entry by
// entry (read, then compare or move), so every request is handled alone
// and in_ready is low until it is done.
// add: scan up to the slot, then shift the tail up.
// kill: scan for the key, then shift the tail down.
// tick with n due: count the due alarms, report them, then close the gap;
// a tick with nothing due gives no result.
// an unused op is dropped.
// results sit in an output register; a new request is taken while a result
// still waits there. when the receiver stalls, the sequencer holds at the
// step that reports the next result until the register frees up.
// reset empties the queue and clears out_valid; stored entries are not cleared.
module sorted_alarm_timer_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] now_time,
	input  logic [31:0] trigger_time,
	input  logic [15:0] alarm_ref,
	input  logic [15:0] owner_key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [31:0] fired_time,
	output logic [15:0] fired_ref,
	output logic [15:0] fired_key,
	output logic        last
);

	staq_pkg::state_t state_q, state_d;

	logic [1:0]  op_q;
	logic [31:0] now_q;
	logic [31:0] trig_q;
	logic [15:0] ref_q;
	logic [15:0] key_q;

	logic [staq_pkg::CW-1:0] count_q;
	logic [staq_pkg::CW-1:0] idx_q;
	logic [staq_pkg::CW-1:0] pos_q;
	logic [staq_pkg::CW-1:0] nfire_q;
	logic [staq_pkg::CW-1:0] delta_q;
	logic                    up_q;

	logic [2:0]  res_kind_q;
	logic [31:0] res_time_q;
	logic [15:0] res_ref_q;
	logic [15:0] res_key_q;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [31:0] time_q;
	logic [15:0] oref_q;
	logic [15:0] okey_q;
	logic        last_q;

	staq_pkg::store_req_t req;
	staq_pkg::entry_t     rd;

	logic                    out_free;
	logic                    load_out;
	logic [staq_pkg::CW-1:0] idx_inc;
	logic [staq_pkg::CW-1:0] dst;
	logic                    at_end;
	logic                    tick_cap;
	logic                    fire_last;
	logic                    expired;
	logic                    full;

	staq_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rd)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = out_free && ((state_q == staq_pkg::ST_FIRE_WAIT) ||
		(state_q == staq_pkg::ST_EMIT));
	assign idx_inc   = idx_q + 1'b1;
	assign at_end    = (idx_inc == count_q);
	assign tick_cap  = (int'(idx_inc) == staq_pkg::MAX_RESULTS);
	assign fire_last = (idx_inc == nfire_q);
	assign dst       = up_q ? idx_inc : (idx_q - delta_q);
	assign expired   = (trigger_time < now_time);
	assign full      = (int'(count_q) == staq_pkg::DEPTH);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			staq_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (op)
						staq_pkg::OP_ADD: begin
							if (expired || full) state_d = staq_pkg::ST_EMIT;
							else if (count_q == '0) state_d = staq_pkg::ST_ADD_INS;
							else state_d = staq_pkg::ST_ADD_RD;
						end
						staq_pkg::OP_KILL: begin
							if (count_q == '0) state_d = staq_pkg::ST_EMIT;
							else state_d = staq_pkg::ST_KILL_RD;
						end
						staq_pkg::OP_TICK: begin
							if (count_q == '0) state_d = staq_pkg::ST_IDLE;
							else state_d = staq_pkg::ST_TICK_RD;
						end
						default: state_d = staq_pkg::ST_IDLE;
					endcase
				end
			end
			staq_pkg::ST_ADD_RD: state_d = staq_pkg::ST_ADD_CHK;
			staq_pkg::ST_ADD_CHK: begin
				if (rd.atime < trig_q) begin
					state_d = at_end ? staq_pkg::ST_ADD_INS : staq_pkg::ST_ADD_RD;
				end else begin
					state_d = staq_pkg::ST_MV_RD;
				end
			end
			staq_pkg::ST_ADD_INS: state_d = staq_pkg::ST_EMIT;
			staq_pkg::ST_MV_RD: state_d = staq_pkg::ST_MV_WR;
			staq_pkg::ST_MV_WR: begin
				if (up_q) begin
					state_d = (idx_q == pos_q) ? staq_pkg::ST_ADD_INS : staq_pkg::ST_MV_RD;
				end else if (at_end) begin
					state_d = (op_q == staq_pkg::OP_KILL) ? staq_pkg::ST_EMIT
						: staq_pkg::ST_IDLE;
				end else begin
					state_d = staq_pkg::ST_MV_RD;
				end
			end
			staq_pkg::ST_KILL_RD: state_d = staq_pkg::ST_KILL_CHK;
			staq_pkg::ST_KILL_CHK: begin
				if (rd.akey == key_q) begin
					state_d = at_end ? staq_pkg::ST_EMIT : staq_pkg::ST_MV_RD;
				end else begin
					state_d = at_end ? staq_pkg::ST_EMIT : staq_pkg::ST_KILL_RD;
				end
			end
			staq_pkg::ST_TICK_RD: state_d = staq_pkg::ST_TICK_CHK;
			staq_pkg::ST_TICK_CHK: begin
				if (rd.atime <= now_q) begin
					state_d = (at_end || tick_cap) ? staq_pkg::ST_FIRE_RD
						: staq_pkg::ST_TICK_RD;
				end else begin
					state_d = (nfire_q == '0) ? staq_pkg::ST_IDLE : staq_pkg::ST_FIRE_RD;
				end
			end
			staq_pkg::ST_FIRE_RD: state_d = staq_pkg::ST_FIRE_WAIT;
			staq_pkg::ST_FIRE_WAIT: begin
				if (out_free) begin
					if (fire_last) begin
						state_d = (nfire_q == count_q) ? staq_pkg::ST_IDLE
							: staq_pkg::ST_MV_RD;
					end else begin
						state_d = staq_pkg::ST_FIRE_RD;
					end
				end
			end
			staq_pkg::ST_EMIT: begin
				if (out_free) state_d = staq_pkg::ST_IDLE;
			end
			default: state_d = staq_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready        = (state_q == staq_pkg::ST_IDLE);
		req.we          = 1'b0;
		req.waddr       = dst[staq_pkg::AW-1:0];
		req.wdata       = rd;
		req.raddr       = idx_q[staq_pkg::AW-1:0];
		case (state_q)
			staq_pkg::ST_MV_WR: begin
				req.we = 1'b1;
			end
			staq_pkg::ST_ADD_INS: begin
				req.we    = 1'b1;
				req.waddr = pos_q[staq_pkg::AW-1:0];
				req.wdata = '{atime: trig_q, aref: ref_q, akey: key_q};
			end
			default: begin
				req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= staq_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				staq_pkg::ST_IDLE: begin
					if (in_valid) begin
						op_q       <= op;
						now_q      <= now_time;
						trig_q     <= trigger_time;
						ref_q      <= alarm_ref;
						key_q      <= owner_key;
						idx_q      <= '0;
						pos_q      <= '0;
						nfire_q    <= '0;
						res_key_q  <= owner_key;
						if (op == staq_pkg::OP_KILL) begin
							res_kind_q <= staq_pkg::KIND_NOTFOUND;
							res_time_q <= '0;
							res_ref_q  <= '0;
						end else begin
							res_time_q <= trigger_time;
							res_ref_q  <= alarm_ref;
							if (expired) res_kind_q <= staq_pkg::KIND_EXPIRED;
							else if (full) res_kind_q <= staq_pkg::KIND_FULL;
							else res_kind_q <= staq_pkg::KIND_ADDED;
						end
					end
				end
				staq_pkg::ST_ADD_CHK: begin
					if (rd.atime < trig_q) begin
						idx_q <= idx_inc;
						pos_q <= idx_inc;
					end else begin
						pos_q <= idx_q;
						idx_q <= count_q - 1'b1;
						up_q  <= 1'b1;
					end
				end
				staq_pkg::ST_ADD_INS: begin
					count_q <= count_q + 1'b1;
				end
				staq_pkg::ST_MV_WR: begin
					if (up_q) begin
						if (idx_q != pos_q) idx_q <= idx_q - 1'b1;
					end else if (at_end) begin
						count_q <= count_q - delta_q;
					end else begin
						idx_q <= idx_inc;
					end
				end
				staq_pkg::ST_KILL_CHK: begin
					if (rd.akey == key_q) begin
						res_kind_q <= staq_pkg::KIND_KILLED;
						res_time_q <= rd.atime;
						res_ref_q  <= rd.aref;
						res_key_q  <= rd.akey;
						delta_q    <= staq_pkg::CW'(1);
						up_q       <= 1'b0;
						if (at_end) count_q <= count_q - 1'b1;
						else idx_q <= idx_inc;
					end else begin
						idx_q <= idx_inc;
					end
				end
				staq_pkg::ST_TICK_CHK: begin
					if (rd.atime <= now_q) begin
						nfire_q <= idx_inc;
						idx_q   <= (at_end || tick_cap) ? '0 : idx_inc;
					end else begin
						idx_q <= '0;
					end
				end
				staq_pkg::ST_FIRE_WAIT: begin
					if (out_free) begin
						kind_q      <= staq_pkg::KIND_FIRED;
						time_q      <= rd.atime;
						oref_q      <= rd.aref;
						okey_q      <= rd.akey;
						last_q      <= fire_last;
						if (fire_last) begin
							delta_q <= nfire_q;
							up_q    <= 1'b0;
							if (nfire_q == count_q) count_q <= '0;
							else idx_q <= nfire_q;
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				staq_pkg::ST_EMIT: begin
					if (out_free) begin
						kind_q      <= res_kind_q;
						time_q      <= res_time_q;
						oref_q      <= res_ref_q;
						okey_q      <= res_key_q;
						last_q      <= 1'b1;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign fired_time = time_q;
	assign fired_ref  = oref_q;
	assign fired_key  = okey_q;
	assign last       = last_q;

endmodule

/* tb/sv/sorted_alarm_timer_queue_checker.sv */
module sorted_alarm_timer_queue_checker
	import staq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] now_time,
	input  logic [31:0] trigger_time,
	input  logic [15:0] alarm_ref,
	input  logic [15:0] owner_key,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] fired_time,
	input  logic [15:0] fired_ref,
	input  logic [15:0] fired_key,
	input  logic        last,
	output int          outstanding,
	output int          mismatches
);

	typedef struct packed {
		logic [2:0] kind;
		entry_t     alarm;
		logic       last;
	} report_t;

	// pending alarms, earliest first
	entry_t  pending_alarms[$];
	report_t awaited_reports[$];

	initial begin
		outstanding = 0;
		mismatches  = 0;
	end

	function automatic void queue_report(input logic [2:0] code, input entry_t alarm,
			input logic is_last);
		report_t rpt;
		rpt.kind  = code;
		rpt.alarm = alarm;
		rpt.last  = is_last;
		awaited_reports.push_back(rpt);
	endfunction

	function automatic void predict_alarm_outcomes(input logic [1:0] code,
			input logic [31:0] now, input entry_t req);
		int slot;
		int hit;
		int fired;
		entry_t missing;
		report_t tail;
		case (code)
			OP_ADD: begin
				if (req.atime < now) begin
					queue_report(KIND_EXPIRED, req, 1'b1);
				end else if (pending_alarms.size() >= DEPTH) begin
					queue_report(KIND_FULL, req, 1'b1);
				end else begin
					slot = 0;
					while (slot < pending_alarms.size() && pending_alarms[slot].atime < req.atime)
						slot++;
					pending_alarms.insert(slot, req);
					queue_report(KIND_ADDED, req, 1'b1);
				end
			end
			OP_KILL: begin
				hit = -1;
				for (int i = 0; i < pending_alarms.size(); i++)
					if (hit < 0 && pending_alarms[i].akey == req.akey)
						hit = i;
				if (hit >= 0) begin
					queue_report(KIND_KILLED, pending_alarms[hit], 1'b1);
					pending_alarms.delete(hit);
				end else begin
					missing       = '0;
					missing.akey  = req.akey;
					queue_report(KIND_NOTFOUND, missing, 1'b1);
				end
			end
			OP_TICK: begin
				fired = 0;
				while (fired < MAX_RESULTS && pending_alarms.size() > 0 &&
						pending_alarms[0].atime <= now) begin
					queue_report(KIND_FIRED, pending_alarms.pop_front(), 1'b0);
					fired++;
				end
				if (fired > 0) begin
					tail      = awaited_reports.pop_back();
					tail.last = 1'b1;
					awaited_reports.push_back(tail);
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(input string tag, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %0h, actual %0h", $time, tag, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		report_t want;
		entry_t req;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_reports.size() == 0) begin
					$display("%0t unexpected result: expected none, actual kind %0d time %0h ref %0h key %0h last %0b",
						$time, kind, fired_time, fired_ref, fired_key, last);
					mismatches++;
				end else begin
					want = awaited_reports.pop_front();
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("fired_time", want.alarm.atime, fired_time);
					check_field("fired_ref", 32'(want.alarm.aref), 32'(fired_ref));
					check_field("fired_key", 32'(want.alarm.akey), 32'(fired_key));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			if (in_valid && in_ready) begin
				req.atime = trigger_time;
				req.aref  = alarm_ref;
				req.akey  = owner_key;
				predict_alarm_outcomes(op, now_time, req);
			end
			outstanding <= awaited_reports.size();
		end
	end

endmodule

/* tb/sv/sorted_alarm_timer_queue_test.sv */
module sorted_alarm_timer_queue_test;
	import staq_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_AFTER   = 80;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_AFTER  = 160;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [31:0] now_time;
	logic [31:0] trigger_time;
	logic [15:0] alarm_ref;
	logic [15:0] owner_key;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  kind;
	logic [31:0] fired_time;
	logic [15:0] fired_ref;
	logic [15:0] fired_key;
	logic        last;
	int          outstanding;
	int          mismatches;

	int          requests_sent;
	logic [31:0] wall;

	sorted_alarm_timer_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.now_time     (now_time),
		.trigger_time (trigger_time),
		.alarm_ref    (alarm_ref),
		.owner_key    (owner_key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.fired_time   (fired_time),
		.fired_ref    (fired_ref),
		.fired_key    (fired_key),
		.last         (last)
	);

	sorted_alarm_timer_queue_checker alarm_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.now_time     (now_time),
		.trigger_time (trigger_time),
		.alarm_ref    (alarm_ref),
		.owner_key    (owner_key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.fired_time   (fired_time),
		.fired_ref    (fired_ref),
		.fired_key    (fired_key),
		.last         (last),
		.outstanding  (outstanding),
		.mismatches   (mismatches)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAIL sorted_alarm_timer_queue");
		$finish;
	end

	task automatic offer_request(input logic [1:0] code, input logic [31:0] now,
			input logic [31:0] trig, input logic [15:0] aref, input logic [15:0] key);
		in_valid     <= 1'b1;
		op           <= code;
		now_time     <= now;
		trigger_time <= trig;
		alarm_ref    <= aref;
		owner_key    <= key;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	function automatic logic [15:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(0, 16'hFFFF));
		return 16'($urandom_range(0, 7));
	endfunction

	// mode 0 balanced, 1 fills the queue, 2 drains it
	task automatic issue_random_request(input int mode, output bit ignored);
		int pick;
		int add_cut;
		int sel;
		logic [31:0] now;
		logic [31:0] trig;
		now     = $urandom;
		trig    = $urandom;
		ignored = 1'b0;
		add_cut = (mode == 1) ? 75 : (mode == 2) ? 25 : 45;
		pick    = $urandom_range(0, 99);
		if (pick < add_cut) begin
			sel = $urandom_range(0, 19);
			if (sel < 2) begin
				now  = wall;
				trig = wall - $urandom_range(1, 100);
			end else if (sel > 2) begin
				now  = wall;
				trig = wall + $urandom_range(0, (mode == 1) ? 400 : 40);
			end
			offer_request(OP_ADD, now, trig, 16'($urandom_range(0, 16'hFFFF)), pick_key());
		end else if (pick < add_cut + 20) begin
			offer_request(OP_KILL, now, trig, 16'($urandom_range(0, 16'hFFFF)), pick_key());
		end else if (pick < 96) begin
			if ($urandom_range(0, 19) != 0) begin
				wall = wall + $urandom_range(0, (mode == 2) ? 120 : 25);
				now  = wall;
			end
			offer_request(OP_TICK, now, trig, 16'($urandom_range(0, 16'hFFFF)),
				16'($urandom_range(0, 16'hFFFF)));
		end else begin
			ignored = 1'b1;
			offer_request(OP_UNUSED, now, trig, 16'($urandom_range(0, 16'hFFFF)),
				16'($urandom_range(0, 16'hFFFF)));
		end
	endtask

	// result side stalls
	initial begin
		int mode;
		int mode_left;
		bit held;
		mode      = 0;
		mode_left = 0;
		held      = 1'b0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && requests_sent >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// request side
	initial begin
		int counted;
		int burst;
		int gap;
		int mode;
		bit ignored;
		bit drained;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_ADD;
		now_time      = '0;
		trigger_time  = '0;
		alarm_ref     = '0;
		owner_key     = '0;
		requests_sent = 0;
		counted       = 0;
		drained       = 1'b0;
		wall          = $urandom >> 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, extremes, ignored op
		offer_request(OP_TICK, 32'd0, $urandom, 16'h5A5A, 16'hA5A5);
		offer_request(OP_KILL, $urandom, $urandom, 16'h0F0F, 16'h1234);
		offer_request(OP_ADD, 32'd0, 32'd0, 16'h0000, 16'h0000);
		offer_request(OP_ADD, 32'd6, 32'd5, 16'h00AA, 16'h0003);
		offer_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		offer_request(OP_KILL, $urandom, $urandom, 16'h0000, 16'hFFFF);
		offer_request(OP_UNUSED, $urandom, $urandom, 16'hFFFF, 16'h0000);
		// fill with repeated times, then overflow, then fire everything
		for (int i = 0; i < 15; i++)
			offer_request(OP_ADD, 32'd0, 32'd40 - 32'(i % 4) * 32'd10, 16'(i), 16'(i % 5));
		offer_request(OP_ADD, 32'd0, 32'd50, 16'hBEEF, 16'h0001);
		offer_request(OP_TICK, 32'hFFFF_FFFF, 32'd0, 16'h0000, 16'h0000);

		while (counted < RANDOM_ITEMS) begin
			mode  = $urandom_range(0, 2);
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && counted < RANDOM_ITEMS; i++) begin
				issue_random_request(mode, ignored);
				if (!ignored)
					counted++;
			end
			if (!drained && requests_sent >= DRAIN_AFTER) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (outstanding != 0);
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("PASS sorted_alarm_timer_queue");
		else
			$display("FAIL sorted_alarm_timer_queue");
		$finish;
	end

endmodule

/* sorted_alarm_timer_queue.f */
sv/staq_pkg.sv
sv/staq_store.sv
sv/sorted_alarm_timer_queue.sv
tb/sv/sorted_alarm_timer_queue_checker.sv
tb/sv/sorted_alarm_timer_queue_test.sv
